@@ hdl/vhbf_pkg.sv @@
package vhbf_pkg;

   localparam int HISTORY_DEPTH = 16;
   localparam int VIEW_WIDTH    = 64;
   localparam int DEPTH_W       = $clog2(HISTORY_DEPTH + 1);

   typedef logic [VIEW_WIDTH-1:0] view_type;
   typedef logic [DEPTH_W-1:0]    depth_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_NEXT  = 2'd2,
      OP_PREV  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_NO_NEXT = 2'd1,
      ERR_NO_PREV = 2'd2,
      ERR_FULL    = 2'd3
   } err_type;

   // cell shift command: PUSH takes the lower neighbor's word, POP the upper one's
   typedef enum logic [1:0] {
      SHIFT_HOLD = 2'd0,
      SHIFT_PUSH = 2'd1,
      SHIFT_POP  = 2'd2
   } shift_type;

   typedef struct packed {
      shift_type cur_shift;
      shift_type fwd_shift;
      view_type  cur_push;
   } chain_ctl_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] view_word;
   } req_type;

   typedef struct packed {
      logic [63:0] current_view;
      logic        current_valid;
      logic [4:0]  forward_count;
      logic [3:0]  backward_count;
      err_type     error_code;
   } rsp_type;

endpackage

@@ hdl/vhbf_cell.sv @@
module vhbf_cell (
   input  logic                clock,
   input  vhbf_pkg::shift_type shift,
   input  vhbf_pkg::view_type  push_word,
   input  vhbf_pkg::view_type  pop_word,
   output vhbf_pkg::view_type  word
);
   import vhbf_pkg::*;

   view_type word_ff;
   view_type word_in;

   always_comb begin
      unique case (shift)
         SHIFT_PUSH: word_in = push_word;
         SHIFT_POP:  word_in = pop_word;
         default:    word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ hdl/vhbf_ctrl.sv @@
module vhbf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  vhbf_pkg::req_type       req_item,
   input  vhbf_pkg::view_type      cur_top,
   input  vhbf_pkg::view_type      cur_below,
   input  vhbf_pkg::view_type      fwd_top,
   output vhbf_pkg::chain_ctl_type chain_ctl,
   output logic                    rsp_strobe,
   output vhbf_pkg::rsp_type       rsp_item
);
   import vhbf_pkg::*;

   depth_type cur_depth_ff, cur_depth_in;
   depth_type fwd_depth_ff, fwd_depth_in;
   logic      rsp_strobe_ff;
   rsp_type   rsp_item_ff, rsp_item_in;

   logic      accept;
   view_type  view;
   view_type  top_next;
   logic      cur_valid;
   logic      valid_next;
   err_type   err;

   assign accept    = start && !reset;
   assign view      = req_item.view_word[VIEW_WIDTH-1:0];
   assign cur_valid = (cur_depth_ff != '0);

   always_comb begin
      cur_depth_in        = cur_depth_ff;
      fwd_depth_in        = fwd_depth_ff;
      err                 = ERR_OK;
      top_next            = cur_top;
      chain_ctl.cur_shift = SHIFT_HOLD;
      chain_ctl.fwd_shift = SHIFT_HOLD;
      chain_ctl.cur_push  = view;
      if (accept) begin
         unique case (req_item.op)
            OP_ADD: begin
               if (cur_valid && cur_top == view) begin
                  // same view as current: no change, forward list kept
               end else if (cur_depth_ff >= DEPTH_W'(HISTORY_DEPTH)) begin
                  err = ERR_FULL;
               end else begin
                  chain_ctl.cur_shift = SHIFT_PUSH;
                  cur_depth_in        = cur_depth_ff + DEPTH_W'(1);
                  fwd_depth_in        = '0;
                  top_next            = view;
               end
            end
            OP_CLEAR: begin
               cur_depth_in = '0;
               fwd_depth_in = '0;
            end
            OP_NEXT: begin
               if (fwd_depth_ff == '0 || cur_depth_ff >= DEPTH_W'(HISTORY_DEPTH)) begin
                  err = ERR_NO_NEXT;
               end else begin
                  chain_ctl.cur_shift = SHIFT_PUSH;
                  chain_ctl.fwd_shift = SHIFT_POP;
                  chain_ctl.cur_push  = fwd_top;
                  cur_depth_in        = cur_depth_ff + DEPTH_W'(1);
                  fwd_depth_in        = fwd_depth_ff - DEPTH_W'(1);
                  top_next            = fwd_top;
               end
            end
            OP_PREV: begin
               if (cur_depth_ff <= DEPTH_W'(1)) begin
                  err = ERR_NO_PREV;
               end else begin
                  chain_ctl.cur_shift = SHIFT_POP;
                  chain_ctl.fwd_shift = SHIFT_PUSH;
                  cur_depth_in        = cur_depth_ff - DEPTH_W'(1);
                  fwd_depth_in        = fwd_depth_ff + DEPTH_W'(1);
                  top_next            = cur_below;
               end
            end
            default: err = ERR_OK;
         endcase
      end
   end

   always_comb begin
      valid_next                 = (cur_depth_in != '0);
      rsp_item_in.current_valid  = valid_next;
      rsp_item_in.current_view   = valid_next ? 64'(top_next) : 64'd0;
      rsp_item_in.forward_count  = 5'(fwd_depth_in);
      rsp_item_in.backward_count = valid_next ? 4'(cur_depth_in - DEPTH_W'(1)) : 4'd0;
      rsp_item_in.error_code     = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_depth_ff  <= '0;
         fwd_depth_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cur_depth_ff  <= cur_depth_in;
         fwd_depth_ff  <= fwd_depth_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // the two lists together never hold more than HISTORY_DEPTH views
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_depth_ff) + 32'(fwd_depth_ff)) <= HISTORY_DEPTH)
      else $error("history lists exceed capacity");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted item without response");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without accepted item");

   a_full_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.error_code == ERR_FULL)
         |-> cur_depth_ff == DEPTH_W'(HISTORY_DEPTH))
      else $error("full error while store not full");

   a_valid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.current_valid == (cur_depth_ff != '0))
      else $error("current_valid disagrees with depth");

endmodule

@@ hdl/view_history_back_forward_stack.sv @@
// A result is strobed on rsp_strobe in the cycle after its request transfer.
// Throughput: one request per cycle while not busy; each op shifts each cell chain at most once.
// busy is high only while reset is asserted; the receiver cannot stall results.
// Reset (synchronous, active high) empties both histories; cell words are left
// as they are and are never read before being written.
module view_history_back_forward_stack (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vhbf_pkg::req_type req_item,
   output logic              rsp_strobe,
   output vhbf_pkg::rsp_type rsp_item
);
   import vhbf_pkg::*;

   // Two chains of HISTORY_DEPTH cells. The current chain holds the current view
   // in cell 0 and older views behind it; the forward chain holds the newest
   // forward view in cell 0. Go previous pops the current chain and pushes its
   // old top onto the forward chain; go next does the reverse. Add pushes the
   // new view on the current chain and simply zeroes the forward count.
   view_type      cur_word [HISTORY_DEPTH];
   view_type      fwd_word [HISTORY_DEPTH];
   chain_ctl_type chain_ctl;

   // no transfer is taken while reset holds the depth registers
   assign busy = reset;

   vhbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .cur_top    (cur_word[0]),
      .cur_below  (cur_word[1]),
      .fwd_top    (fwd_word[0]),
      .chain_ctl  (chain_ctl),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      view_type cur_push_src, cur_pop_src;
      view_type fwd_push_src, fwd_pop_src;

      // cell 0 is fed from the controller (current) or the current top (forward);
      // the last cell pops in a don't-care zero
      if (i == 0) begin : g_head
         assign cur_push_src = chain_ctl.cur_push;
         assign fwd_push_src = cur_word[0];
      end else begin : g_body
         assign cur_push_src = cur_word[i-1];
         assign fwd_push_src = fwd_word[i-1];
      end

      if (i == HISTORY_DEPTH - 1) begin : g_tail
         assign cur_pop_src = '0;
         assign fwd_pop_src = '0;
      end else begin : g_inner
         assign cur_pop_src = cur_word[i+1];
         assign fwd_pop_src = fwd_word[i+1];
      end

      vhbf_cell u_cur (
         .clock     (clock),
         .shift     (chain_ctl.cur_shift),
         .push_word (cur_push_src),
         .pop_word  (cur_pop_src),
         .word      (cur_word[i])
      );

      vhbf_cell u_fwd (
         .clock     (clock),
         .shift     (chain_ctl.fwd_shift),
         .push_word (fwd_push_src),
         .pop_word  (fwd_pop_src),
         .word      (fwd_word[i])
      );
   end

endmodule
